/* src/lgpb_pkg.sv */
// ----------------------------------------------------------------------------
// lgpb_pkg: shared types and constants for the linear gradient pixel blend
// Register indexes, color layout, blend modes and the per-pixel side band.
// ----------------------------------------------------------------------------
package lgpb_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COLOR_BITS     = 8;
  localparam int unsigned NUM_CH         = 3;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 24;
  // one quotient bit per divider stage
  localparam int unsigned DIV_STEPS      = COLOR_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_START_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR = 3'd4;

  typedef enum logic [1:0] {
    MODE_DRAW,
    MODE_OLD,
    MODE_MIX
  } mode_e;

  typedef struct packed {
    logic                                in_region;
    mode_e                               mode;
    logic [NUM_CH-1:0][COLOR_BITS-1:0]   old_rgb;
  } side_t;

endpackage

/* src/linear_gradient_pixel_blend.sv */
// ----------------------------------------------------------------------------
// linear_gradient_pixel_blend: linear gradient fill of RGB888 pixels
// Shades a pixel stream with a gradient from the draw color to the old color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one pixel beat per cycle:
//   coordinates, region flag and old color. Output channel
//   (out_valid_o/out_ready_i) returns one beat per pixel, in order, with
//   write_pixel_o and the new color (zero color when outside the region).
//   The pipeline has five projection/blend stages, eight divider stages
//   (one quotient bit each) and the output register. Throughput is one
//   pixel per cycle; when the receiver stalls the whole pipeline holds and
//   in_ready_o drops; nothing is dropped or repeated. Reset clears all
//   valid bits and the registers (start, end, draw color). The user must
//   write registers through cfg_we_i/cfg_idx_i/cfg_wdata_i only while no
//   pixel is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module linear_gradient_pixel_blend #(
  parameter int unsigned COORD_BITS = lgpb_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lgpb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lgpb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [COORD_BITS-1:0]              pixel_x_i,
  input  logic [COORD_BITS-1:0]              pixel_y_i,
  input  logic                               in_region_i,
  input  logic [lgpb_pkg::COLOR_BITS-1:0]    old_red_i,
  input  logic [lgpb_pkg::COLOR_BITS-1:0]    old_green_i,
  input  logic [lgpb_pkg::COLOR_BITS-1:0]    old_blue_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               write_pixel_o,
  output logic [lgpb_pkg::COLOR_BITS-1:0]    new_red_o,
  output logic [lgpb_pkg::COLOR_BITS-1:0]    new_green_o,
  output logic [lgpb_pkg::COLOR_BITS-1:0]    new_blue_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned DW    = CW + 1;         // signed coordinate delta
  localparam int unsigned PW    = 2 * DW;         // signed product
  localparam int unsigned CSW   = PW + 1;         // signed projection
  localparam int unsigned SPW   = 2 * CW + 1;     // span = A*A + B*B
  localparam int unsigned QW    = lgpb_pkg::COLOR_BITS;
  localparam int unsigned NW    = SPW + QW;
  localparam int unsigned NCH   = lgpb_pkg::NUM_CH;
  localparam int unsigned STEPS = lgpb_pkg::DIV_STEPS;

  // ---------------- configuration registers
  logic [CW-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic [lgpb_pkg::CFG_DATA_W-1:0] draw_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q    <= '0;
      start_y_q    <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      draw_color_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lgpb_pkg::REG_START_X:    start_x_q    <= cfg_wdata_i[CW-1:0];
        lgpb_pkg::REG_START_Y:    start_y_q    <= cfg_wdata_i[CW-1:0];
        lgpb_pkg::REG_END_X:      end_x_q      <= cfg_wdata_i[CW-1:0];
        lgpb_pkg::REG_END_Y:      end_y_q      <= cfg_wdata_i[CW-1:0];
        lgpb_pkg::REG_DRAW_COLOR: draw_color_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [NCH-1:0][QW-1:0] draw_rgb;
  for (genvar c = 0; c < NCH; c++) begin : g_draw
    assign draw_rgb[c] = draw_color_q[(NCH-1-c)*QW +: QW];
  end

  // global advance: the pipeline moves when the output slot is free or taken
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage 1: products
  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] prod_d [6];
  logic signed [PW-1:0] s1_prod_q [6];
  lgpb_pkg::side_t      in_side, s1_side_q;
  logic                 s1_valid_q;

  assign dx = $signed({1'b0, end_x_q}) - $signed({1'b0, start_x_q});
  assign dy = $signed({1'b0, end_y_q}) - $signed({1'b0, start_y_q});

  always_comb begin
    prod_d[0] = PW'(dx) * PW'($signed({1'b0, pixel_x_i}));
    prod_d[1] = PW'(dy) * PW'($signed({1'b0, pixel_y_i}));
    prod_d[2] = PW'(dx) * PW'($signed({1'b0, start_x_q}));
    prod_d[3] = PW'(dy) * PW'($signed({1'b0, start_y_q}));
    prod_d[4] = PW'(dx) * PW'($signed({1'b0, end_x_q}));
    prod_d[5] = PW'(dy) * PW'($signed({1'b0, end_y_q}));
  end

  always_comb begin
    in_side.in_region  = in_region_i;
    in_side.mode       = lgpb_pkg::MODE_OLD;
    in_side.old_rgb[0] = old_red_i;
    in_side.old_rgb[1] = old_green_i;
    in_side.old_rgb[2] = old_blue_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q <= prod_d;
      s1_side_q <= in_side;
    end
  end

  // ---------------- stage 2: projections C, C1, C2
  logic signed [CSW-1:0] s2_c_q, s2_c1_q, s2_c2_q;
  lgpb_pkg::side_t       s2_side_q;
  logic                  s2_valid_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_c_q    <= CSW'(s1_prod_q[0]) + CSW'(s1_prod_q[1]);
      s2_c1_q   <= CSW'(s1_prod_q[2]) + CSW'(s1_prod_q[3]);
      s2_c2_q   <= CSW'(s1_prod_q[4]) + CSW'(s1_prod_q[5]);
      s2_side_q <= s1_side_q;
    end
  end

  // ---------------- stage 3: compare, weights and span
  logic signed [CSW-1:0] up_w, down_w, span_w;
  lgpb_pkg::side_t       s3_side_d, s3_side_q;
  logic [SPW-1:0]        s3_up_q, s3_down_q, s3_span_q;
  logic                  s3_valid_q;

  assign up_w   = s2_c_q - s2_c1_q;
  assign down_w = s2_c2_q - s2_c_q;
  assign span_w = s2_c2_q - s2_c1_q;

  always_comb begin
    s3_side_d = s2_side_q;
    priority if (s2_c_q < s2_c1_q) begin
      s3_side_d.mode = lgpb_pkg::MODE_DRAW;
    end else if (s2_c_q >= s2_c2_q) begin
      s3_side_d.mode = lgpb_pkg::MODE_OLD;
    end else begin
      s3_side_d.mode = lgpb_pkg::MODE_MIX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_up_q   <= up_w[SPW-1:0];
      s3_down_q <= down_w[SPW-1:0];
      s3_span_q <= span_w[SPW-1:0];
      s3_side_q <= s3_side_d;
    end
  end

  // ---------------- stage 4: weighted channel products
  logic [NCH-1:0][NW-1:0] s4_old_p_q, s4_draw_p_q;
  logic [SPW-1:0]         s4_span_q;
  lgpb_pkg::side_t        s4_side_q;
  logic                   s4_valid_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NCH; c++) begin
        s4_old_p_q[c]  <= NW'(s3_side_q.old_rgb[c]) * NW'(s3_up_q);
        s4_draw_p_q[c] <= NW'(draw_rgb[c]) * NW'(s3_down_q);
      end
      s4_span_q <= s3_span_q;
      s4_side_q <= s3_side_q;
    end
  end

  // ---------------- stage 5: numerators
  logic [NCH-1:0][NW-1:0] s5_num_q;
  logic [SPW-1:0]         s5_span_q;
  lgpb_pkg::side_t        s5_side_q;
  logic                   s5_valid_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NCH; c++) begin
        s5_num_q[c] <= s4_old_p_q[c] + s4_draw_p_q[c];
      end
      s5_span_q <= s4_span_q;
      s5_side_q <= s4_side_q;
    end
  end

  // ---------------- divider stages
  logic [NCH-1:0][QW-1:0] quo;

  lgpb_div #(
    .DEN_W (SPW)
  ) u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s5_num_q),
    .den_i (s5_span_q),
    .quo_o (quo)
  );

  lgpb_pkg::side_t  div_side_q [STEPS];
  logic [STEPS-1:0] div_valid_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_side_q[0] <= s5_side_q;
      for (int k = 1; k < STEPS; k++) begin
        div_side_q[k] <= div_side_q[k-1];
      end
    end
  end

  // ---------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      div_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      div_valid_q <= {div_valid_q[STEPS-2:0], s5_valid_q};
      out_valid_q <= div_valid_q[STEPS-1];
    end
  end

  // ---------------- output register
  lgpb_pkg::side_t        fin_side;
  logic [NCH-1:0][QW-1:0] rgb_d, rgb_q;
  logic                   write_q;

  assign fin_side = div_side_q[STEPS-1];

  always_comb begin
    rgb_d = '0;
    if (fin_side.in_region) begin
      unique case (fin_side.mode)
        lgpb_pkg::MODE_DRAW: rgb_d = draw_rgb;
        lgpb_pkg::MODE_OLD:  rgb_d = fin_side.old_rgb;
        lgpb_pkg::MODE_MIX:  rgb_d = quo;
        default:             rgb_d = fin_side.old_rgb;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rgb_q   <= rgb_d;
      write_q <= fin_side.in_region;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign write_pixel_o = write_q;
  assign new_red_o     = rgb_q[0];
  assign new_green_o   = rgb_q[1];
  assign new_blue_o    = rgb_q[2];

`ifndef ASSERT_OFF
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_pixel_o |->
      new_red_o == '0 && new_green_o == '0 && new_blue_o == '0)
    else $error("pixel outside region carries a nonzero color");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted beat not captured in first stage");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(div_valid_q) && $stable(s5_valid_q) && $stable(s1_valid_q))
    else $error("pipeline moved during stall");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && div_valid_q[STEPS-1] |=> out_valid_o)
    else $error("last divider beat not delivered to output");
`endif

endmodule

/* src/lgpb_div.sv */
// ----------------------------------------------------------------------------
// lgpb_div: pipelined restoring divider, three channels sharing one divisor
// One quotient bit per stage, MSB first; quotient is known to fit the color.
// ----------------------------------------------------------------------------
module lgpb_div #(
  parameter int unsigned DEN_W = 25
) (
  input  logic                                                   clk_i,
  input  logic                                                   en_i,
  input  logic [lgpb_pkg::NUM_CH-1:0][DEN_W+lgpb_pkg::COLOR_BITS-1:0] num_i,
  input  logic [DEN_W-1:0]                                       den_i,
  output logic [lgpb_pkg::NUM_CH-1:0][lgpb_pkg::COLOR_BITS-1:0]  quo_o
);

  localparam int unsigned NW    = DEN_W + lgpb_pkg::COLOR_BITS;
  localparam int unsigned NCH   = lgpb_pkg::NUM_CH;
  localparam int unsigned QW    = lgpb_pkg::COLOR_BITS;
  localparam int unsigned STEPS = lgpb_pkg::DIV_STEPS;

  logic [NCH-1:0][NW-1:0] rem_q [STEPS];
  logic [NCH-1:0][QW-1:0] quo_q [STEPS];
  logic [DEN_W-1:0]       den_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int unsigned SH = STEPS - 1 - k;
    logic [NCH-1:0][NW-1:0] rem_in;
    logic [NCH-1:0][QW-1:0] quo_in;
    logic [DEN_W-1:0]       den_in;
    logic [NW-1:0]          den_sh;
    logic [NCH-1:0][NW-1:0] rem_d;
    logic [NCH-1:0][QW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign den_sh = NW'(den_in) << SH;

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int c = 0; c < NCH; c++) begin
        if (rem_in[c] >= den_sh) begin
          rem_d[c]     = rem_in[c] - den_sh;
          quo_d[c][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[STEPS-1];

endmodule
